// ===== hdl/vde_pkg.sv =====
// ----------------------------------------------------------------------------
// vde_pkg
// Shared types and constants of the vector distance engine.
// ----------------------------------------------------------------------------
package vde_pkg;

  localparam int unsigned MaxLengthDefault = 1024;
  localparam int unsigned DataWidthDefault = 16;

  localparam int unsigned ValW  = 16;  // width of one element on the stream
  localparam int unsigned ModeW = 3;
  localparam int unsigned AccW  = 45;
  localparam int unsigned RmaxW = 17;
  localparam int unsigned DistW = 60;
  localparam int unsigned FracW = 16;

  typedef enum logic [ModeW-1:0] {
    MODE_EUCLIDEAN = 3'd0,
    MODE_MANHATTAN = 3'd1,
    MODE_MAXIMUM   = 3'd2,
    MODE_BINARY    = 3'd3,
    MODE_MATCHING  = 3'd4
  } metric_mode_e;

  typedef struct packed {
    logic accum;      // fold the accepted pair into the vector state
    logic mul;        // form acc * offered and decide the result path
    logic prep;       // load the divider, clear the vector state
    logic div_step;   // one quotient bit
    logic div_done;   // take the quotient
    logic sqrt_step;  // one root bit
    logic load_out;   // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_sqrt;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hdl/vde_ctrl.sv =====
// ----------------------------------------------------------------------------
// vde_ctrl
// Sequencer: accumulation, product, bit-serial divide, bit-serial root, output.
// ----------------------------------------------------------------------------
module vde_ctrl #(
  parameter int unsigned NUM_W  = 88,
  parameter int unsigned ROOT_W = 44
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  vde_pkg::dp_status_t status_i,
  output vde_pkg::dp_cmd_t    cmd_o
);
  import vde_pkg::*;

  localparam int unsigned IterW = $clog2(NUM_W + 1);

  typedef enum logic [2:0] {
    S_ACC, S_MUL, S_PREP, S_DIV, S_SQRT, S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [IterW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_ACC: begin
        in_ready_o  = 1'b1;
        cmd_o.accum = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = IterW'(NUM_W);
        state_d    = status_i.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (cnt_q != '0) begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q - 1'b1;
        end else begin
          cmd_o.div_done = 1'b1;
          cnt_d          = IterW'(ROOT_W);
          state_d        = status_i.need_sqrt ? S_SQRT : S_DONE;
        end
      end
      S_SQRT: begin
        if (cnt_q != '0) begin
          cmd_o.sqrt_step = 1'b1;
          cnt_d           = cnt_q - 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/vde_datapath.sv =====
// ----------------------------------------------------------------------------
// vde_datapath
// Per-vector state, shared restoring divider, digit-by-digit square root and
// the output register.
// ----------------------------------------------------------------------------
module vde_datapath #(
  parameter int unsigned MAX_LENGTH = 1024,
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned NUM_W      = 88,
  parameter int unsigned ROOT_W     = 44
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vde_pkg::ModeW-1:0]   cfg_wdata_i,
  input  logic [vde_pkg::ValW-1:0]    x_value_i,
  input  logic [vde_pkg::ValW-1:0]    y_value_i,
  input  logic                        x_missing_i,
  input  logic                        y_missing_i,
  input  vde_pkg::dp_cmd_t            cmd_i,
  output vde_pkg::dp_status_t         status_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [vde_pkg::DistW-1:0]   distance_o,
  output logic                        result_missing_o,
  output logic                        too_long_o
);
  import vde_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_LENGTH + 1);
  localparam int unsigned ProdW = AccW + CntW;
  localparam int unsigned RadW  = 2 * ROOT_W;
  localparam int unsigned SremW = ROOT_W + 2;
  localparam int unsigned SqW   = 2 * DATA_WIDTH;
  localparam int unsigned SumW  = ((SqW > AccW) ? SqW : AccW) + 1;
  localparam int unsigned DW    = (DATA_WIDTH > RmaxW) ? DATA_WIDTH : RmaxW;
  localparam int unsigned PadW  = (DATA_WIDTH > ValW) ? DATA_WIDTH : ValW;

  localparam logic [SumW-1:0]  AccMax  = SumW'({AccW{1'b1}});
  localparam logic [DW-1:0]    RmaxMax = DW'({RmaxW{1'b1}});
  localparam logic [DistW-1:0] DistMax = '1;

  logic [ModeW-1:0] mode_q;
  logic [AccW-1:0]  acc_q;
  logic [RmaxW-1:0] rmax_q;
  logic [CntW-1:0]  off_q, use_q, nz_q, dif_q;
  logic             ovf_q;

  logic [ProdW-1:0] prod_q;
  logic             need_div_q, need_sqrt_q;
  logic [DistW-1:0] res_q;
  logic             res_miss_q, res_long_q;

  logic [NUM_W-1:0]  num_q;
  logic [CntW-1:0]   den_q;
  logic [CntW-1:0]   rem_q;
  logic [RadW-1:0]   rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [SremW-1:0]  srem_q;

  logic              out_valid_q;
  logic [DistW-1:0]  out_dist_q;
  logic              out_miss_q, out_long_q;

  // Element decode: the low DATA_WIDTH bits as two's complement.
  logic [PadW-1:0]            x_pad, y_pad;
  logic signed [DATA_WIDTH:0] xs, ys;
  logic [DATA_WIDTH+1:0]      diff, diff_neg;
  logic [DATA_WIDTH-1:0]      absd;
  logic [SqW-1:0]             sq;
  logic [SumW-1:0]            sum;
  logic [DW-1:0]              absd_sat;
  logic                       skip, x_nz, y_nz;

  assign x_pad    = PadW'(x_value_i);
  assign y_pad    = PadW'(y_value_i);
  assign xs       = {x_pad[DATA_WIDTH-1], x_pad[DATA_WIDTH-1:0]};
  assign ys       = {y_pad[DATA_WIDTH-1], y_pad[DATA_WIDTH-1:0]};
  assign diff     = {xs[DATA_WIDTH], xs} - {ys[DATA_WIDTH], ys};
  assign diff_neg = ~diff + 1'b1;
  assign absd     = diff[DATA_WIDTH+1] ? diff_neg[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
  assign sq       = absd * absd;
  assign sum      = SumW'(acc_q) + ((mode_q == MODE_EUCLIDEAN) ? SumW'(sq) : SumW'(absd));
  assign absd_sat = (DW'(absd) > RmaxMax) ? RmaxMax : DW'(absd);
  assign skip     = x_missing_i | y_missing_i;
  assign x_nz     = |xs;
  assign y_nz     = |ys;

  // Divider and root steps.
  logic [CntW:0]     rem_sh;
  logic              qbit;
  logic [SremW+1:0]  srem_sh, trial;
  logic              rbit;

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign qbit    = rem_sh >= {1'b0, den_q};
  assign srem_sh = {srem_q, rad_q[RadW-1:RadW-2]};
  assign trial   = (SremW+2)'({root_q, 2'b01});
  assign rbit    = srem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeW'(MODE_EUCLIDEAN);
      acc_q       <= '0;
      rmax_q      <= '0;
      off_q       <= '0;
      use_q       <= '0;
      nz_q        <= '0;
      dif_q       <= '0;
      ovf_q       <= 1'b0;
      need_div_q  <= 1'b0;
      need_sqrt_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.accum) begin
        if (off_q >= CntW'(MAX_LENGTH)) begin
          ovf_q <= 1'b1;
        end else begin
          off_q <= off_q + 1'b1;
          if (!skip) begin
            use_q <= use_q + 1'b1;
            unique case (mode_q)
              MODE_EUCLIDEAN, MODE_MANHATTAN: begin
                acc_q <= (sum > AccMax) ? AccMax[AccW-1:0] : sum[AccW-1:0];
              end
              MODE_MAXIMUM: begin
                if (absd_sat > DW'(rmax_q)) begin
                  rmax_q <= absd_sat[RmaxW-1:0];
                end
              end
              MODE_BINARY: begin
                if (x_nz || y_nz) begin
                  nz_q <= nz_q + 1'b1;
                  if (!x_nz || !y_nz) begin
                    dif_q <= dif_q + 1'b1;
                  end
                end
              end
              MODE_MATCHING: begin
                if (xs != ys) begin
                  dif_q <= dif_q + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      if (cmd_i.mul) begin
        if (ovf_q || use_q == '0) begin
          need_div_q  <= 1'b0;
          need_sqrt_q <= 1'b0;
        end else begin
          unique case (mode_q)
            MODE_EUCLIDEAN: begin
              need_div_q  <= 1'b1;
              need_sqrt_q <= 1'b1;
            end
            MODE_MANHATTAN, MODE_MATCHING: begin
              need_div_q  <= 1'b1;
              need_sqrt_q <= 1'b0;
            end
            MODE_BINARY: begin
              need_div_q  <= (nz_q != '0);
              need_sqrt_q <= 1'b0;
            end
            default: begin
              need_div_q  <= 1'b0;
              need_sqrt_q <= 1'b0;
            end
          endcase
        end
      end
      if (cmd_i.prep) begin
        acc_q  <= '0;
        rmax_q <= '0;
        off_q  <= '0;
        use_q  <= '0;
        nz_q   <= '0;
        dif_q  <= '0;
        ovf_q  <= 1'b0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q     <= acc_q * off_q;
      res_long_q <= ovf_q;
      res_miss_q <= !ovf_q && (use_q == '0 || mode_q > ModeW'(MODE_MATCHING));
      res_q      <= (!ovf_q && use_q != '0 && mode_q == MODE_MAXIMUM) ?
                    DistW'({rmax_q, {FracW{1'b0}}}) : '0;
    end
    if (cmd_i.prep) begin
      rem_q <= '0;
      den_q <= (mode_q == MODE_BINARY) ? nz_q : use_q;
      unique case (mode_q)
        MODE_EUCLIDEAN: num_q <= NUM_W'({prod_q, 32'b0});
        MODE_MANHATTAN: num_q <= NUM_W'({prod_q, {FracW{1'b0}}});
        default:        num_q <= NUM_W'({dif_q, {FracW{1'b0}}});
      endcase
    end
    if (cmd_i.div_step) begin
      rem_q <= qbit ? CntW'(rem_sh - {1'b0, den_q}) : rem_sh[CntW-1:0];
      num_q <= {num_q[NUM_W-2:0], qbit};
    end
    if (cmd_i.div_done) begin
      rad_q  <= RadW'(num_q);
      root_q <= '0;
      srem_q <= '0;
      res_q  <= (|num_q[NUM_W-1:DistW]) ? DistMax : num_q[DistW-1:0];
    end
    if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      srem_q <= rbit ? SremW'(srem_sh - trial) : SremW'(srem_sh);
      root_q <= {root_q[ROOT_W-2:0], rbit};
    end
    if (cmd_i.load_out) begin
      out_dist_q <= need_sqrt_q ? DistW'(root_q) : res_q;
      out_miss_q <= res_miss_q;
      out_long_q <= res_long_q;
    end
  end

  assign status_o.need_div  = need_div_q;
  assign status_o.need_sqrt = need_sqrt_q;
  assign status_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign distance_o       = out_dist_q;
  assign result_missing_o = out_miss_q;
  assign too_long_o       = out_long_q;

endmodule

// ===== hdl/vector_distance_engine_core.sv =====
// ----------------------------------------------------------------------------
// vector_distance_engine_core
// Streaming distance between two vectors with missing elements.
// ----------------------------------------------------------------------------
// Input beats carry one element pair: x in tdata[15:0], y in tdata[31:16],
// the two missing flags in tuser, and tlast on the closing pair. Each pair
// is folded into the vector state as it is taken, back to back.
// After the closing beat the engine stops taking input while it finishes:
// it forms acc * offered, sets up the divider, then a restoring divider
// yields one quotient bit per cycle over NUM_W bits (88 by default)
// and, in euclidean mode, a square root unit that yields one root bit per
// cycle over ROOT_W bits (44 by default). Results that need no divide
// (maximum, missing, too long) go from setup straight to the output.
// The output register decouples the two sides: the next vector streams in
// while a result waits; only a second result stalls until the first beat
// is taken. Reset clears the vector state, the mode (euclidean) and the
// output valid. Write metric_mode only while the engine is idle.
// ----------------------------------------------------------------------------
module vector_distance_engine_core #(
  parameter int unsigned MAX_LENGTH = vde_pkg::MaxLengthDefault,
  parameter int unsigned DATA_WIDTH = vde_pkg::DataWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,         // metric_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,      // x_value, y_value
  input  logic [1:0]  s_axis_tuser_i,      // x_missing, y_missing
  input  logic        s_axis_tlast_i,      // last_element
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,      // distance, zero fill
  output logic [1:0]  m_axis_tuser_o       // result_missing, too_long
);
  import vde_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_LENGTH + 1);
  localparam int unsigned NumW  = AccW + CntW + 32;
  localparam int unsigned RootW = (NumW + 1) / 2;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [DistW-1:0] distance;

  vde_ctrl #(
    .NUM_W  (NumW),
    .ROOT_W (RootW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vde_datapath #(
    .MAX_LENGTH (MAX_LENGTH),
    .DATA_WIDTH (DATA_WIDTH),
    .NUM_W      (NumW),
    .ROOT_W     (RootW)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .x_value_i        (s_axis_tdata_i[15:0]),
    .y_value_i        (s_axis_tdata_i[31:16]),
    .x_missing_i      (s_axis_tuser_i[0]),
    .y_missing_i      (s_axis_tuser_i[1]),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .distance_o       (distance),
    .result_missing_o (m_axis_tuser_o[0]),
    .too_long_o       (m_axis_tuser_o[1])
  );

  assign m_axis_tdata_o = {4'b0000, distance};

endmodule
